FILE: sv/cfrw_pkg.sv
// Shared types and constants for the checksummed frame receiver.
// Used by every module of the block; depends on nothing.
package cfrw_pkg;

	localparam int DEF_PAYLOAD_BYTES = 57;
	localparam int IDX_W = 6;
	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 8;

	localparam logic [BYTE_W-1:0] HEADER_MARK = 8'hAA;
	localparam logic [BYTE_W-1:0] TRAILER_MARK = 8'h55;
	localparam logic [BYTE_W-1:0] RELOAD_RST = 8'd250;
	localparam logic [BYTE_W-1:0] THRESH_RST = 8'd50;

	localparam logic [CFG_IDX_W-1:0] REG_RELOAD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH = 8'd1;

	typedef enum logic [2:0] {
		ST_OK,
		ST_SHORT,
		ST_BAD_HDR,
		ST_BAD_TRL,
		ST_BAD_SUM
	} status_t;

	// one result item
	typedef struct packed {
		logic              kind;
		logic [IDX_W-1:0]  idx;
		logic [BYTE_W-1:0] pbyte;
		logic              last;
		status_t           status;
		logic              lost;
	} res_t;

	// frame checker to top: store write and verdict of the current item
	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		logic             done;
		logic             accept;
		status_t          status;
		logic             lost;
	} chk_t;

endpackage

FILE: sv/cfrw_payload_ram.sv
// Payload store: simple dual-port RAM, one write and one registered read a cycle.
// Depends on cfrw_pkg for the byte width.
module cfrw_payload_ram #(
	parameter int DEPTH = 2 * cfrw_pkg::DEF_PAYLOAD_BYTES
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [cfrw_pkg::BYTE_W-1:0] wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [cfrw_pkg::BYTE_W-1:0] rdata
);
	import cfrw_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/cfrw_frame_check.sv
// Packet state, frame verdict and link watchdog.
// Depends on cfrw_pkg; drives the payload store write through chk.
module cfrw_frame_check #(
	parameter int PAYLOAD_BYTES = cfrw_pkg::DEF_PAYLOAD_BYTES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic                        command,
	input  logic [cfrw_pkg::BYTE_W-1:0] rx_byte,
	input  logic                        end_flag,
	input  logic [cfrw_pkg::BYTE_W-1:0] reload,
	input  logic [cfrw_pkg::BYTE_W-1:0] threshold,
	output cfrw_pkg::chk_t              chk
);
	import cfrw_pkg::*;

	localparam int FRAME_BYTES = PAYLOAD_BYTES + 3;
	localparam int POS_W = $clog2(FRAME_BYTES + 1);
	localparam logic [POS_W-1:0] POS_PAY = POS_W'(PAYLOAD_BYTES);
	localparam logic [POS_W-1:0] POS_SUM = POS_W'(PAYLOAD_BYTES + 1);
	localparam logic [POS_W-1:0] POS_TRL = POS_W'(PAYLOAD_BYTES + 2);
	localparam logic [POS_W-1:0] POS_FRAME = POS_W'(FRAME_BYTES);

	logic [POS_W-1:0]  pos_q, pos_nx;
	logic [BYTE_W-1:0] sum_q, sum_nx;
	logic              hdr_q, hdr_nx;
	logic              csum_q, csum_nx;
	logic              trl_q, trl_nx;
	logic [BYTE_W-1:0] wd_q;
	logic              lost_q;
	logic              in_pay;
	logic              wd_low;
	status_t           verdict;

	always_comb begin
		in_pay = (pos_q != '0) && (pos_q <= POS_PAY);
		pos_nx = (pos_q < POS_FRAME) ? pos_q + 1'b1 : pos_q;
		hdr_nx = (pos_q == '0) ? (rx_byte == HEADER_MARK) : hdr_q;
		sum_nx = in_pay ? sum_q + rx_byte : sum_q;
		csum_nx = (pos_q == POS_SUM) ? (rx_byte == sum_q) : csum_q;
		trl_nx = (pos_q == POS_TRL) ? (rx_byte == TRAILER_MARK) : trl_q;

		// priority: short, header, trailer, checksum
		if (pos_nx < POS_FRAME) begin
			verdict = ST_SHORT;
		end else if (!hdr_nx) begin
			verdict = ST_BAD_HDR;
		end else if (!trl_nx) begin
			verdict = ST_BAD_TRL;
		end else if (!csum_nx) begin
			verdict = ST_BAD_SUM;
		end else begin
			verdict = ST_OK;
		end

		wd_low = (wd_q <= threshold);

		chk.wr_en = fire && !command && in_pay;
		chk.wr_idx = IDX_W'(pos_q - 1'b1);
		chk.done = command || end_flag;
		chk.accept = !command && end_flag && (verdict == ST_OK);
		chk.status = command ? ST_OK : verdict;
		if (command) begin
			chk.lost = wd_low ? 1'b1 : lost_q;
		end else begin
			chk.lost = chk.accept ? 1'b0 : lost_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
			hdr_q <= 1'b0;
			csum_q <= 1'b0;
			trl_q <= 1'b0;
			wd_q <= '0;
			lost_q <= 1'b1;
		end else if (fire) begin
			if (command) begin
				if (wd_low) begin
					lost_q <= 1'b1;
				end else begin
					wd_q <= wd_q - 1'b1;
				end
			end else if (end_flag) begin
				pos_q <= '0;
				sum_q <= '0;
				hdr_q <= 1'b0;
				csum_q <= 1'b0;
				trl_q <= 1'b0;
				if (chk.accept) begin
					wd_q <= reload;
					lost_q <= 1'b0;
				end
			end else begin
				pos_q <= pos_nx;
				sum_q <= sum_nx;
				hdr_q <= hdr_nx;
				csum_q <= csum_nx;
				trl_q <= trl_nx;
			end
		end
	end

endmodule

FILE: sv/cfrw_out_queue.sv
// Two-entry result queue in front of the master stream port.
// Depends on cfrw_pkg for the result record.
module cfrw_out_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cfrw_pkg::res_t push_data,
	input  logic           pop,
	output logic           head_valid,
	output cfrw_pkg::res_t head,
	output logic [1:0]     count
);
	import cfrw_pkg::*;

	res_t       ent_q [2];
	logic       rd_ptr_q;
	logic       wr_ptr_q;
	logic [1:0] cnt_q;

	assign head_valid = (cnt_q != 2'd0);
	assign head = ent_q[rd_ptr_q];
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> (cnt_q != 2'd2 || pop))
		else $error("result queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> cnt_q != 2'd0)
		else $error("result queue underflow");

endmodule

FILE: sv/checksummed_frame_receiver_watchdog.sv
// Frame receiver top: stream ports, config registers, payload drain sequencer.
// Depends on cfrw_pkg, cfrw_payload_ram, cfrw_frame_check and cfrw_out_queue.
// Throughput: one input item per cycle, ticks and closing bytes only with a free result
// slot; an accepted frame drains its payload at one item per cycle while a slot is free,
// from the RAM bank that the next packet does not fill. Each result is registered in s1,
// then queued. Ticks and closing bytes wait while a drain runs.
// Reset: asynchronous, clears control state only; the payload RAM needs no clearing pass.
module checksummed_frame_receiver_watchdog #(
	parameter int PAYLOAD_BYTES = cfrw_pkg::DEF_PAYLOAD_BYTES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // rx_byte
	input  logic                           s_tuser,   // command
	input  logic                           s_tlast,   // packet_end
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [23:0]                    m_tdata,   // payload_index, payload_byte,
	                                                  // frame_status, link_lost, zero pad
	output logic                           m_tuser,   // result_kind
	output logic                           m_tlast,   // run_last
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cfrw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cfrw_pkg::BYTE_W-1:0]    cfg_data
);
	import cfrw_pkg::*;

	localparam int DEPTH = 2 * PAYLOAD_BYTES;
	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] BANK_OFS = AW'(PAYLOAD_BYTES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

	logic [BYTE_W-1:0] reload_q, thresh_q;
	logic              wr_bank_q, drain_bank_q, drain_busy_q;
	logic [IDX_W-1:0]  drain_idx_q;
	logic              v_s1;
	res_t              res_s1;
	res_t              push_data, head;
	logic              head_valid, pop, slot_free, issue_rd, in_fire, rslt_item;
	logic [1:0]        q_count, occ;
	logic [AW-1:0]     waddr, raddr;
	logic [BYTE_W-1:0] rdata;
	chk_t              chk;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= RELOAD_RST;
			thresh_q <= THRESH_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_RELOAD) begin
				reload_q <= cfg_data;
			end else if (cfg_index == REG_THRESH) begin
				thresh_q <= cfg_data;
			end
		end
	end

	// slot accounting covers the item in s1 and the queue entries
	assign pop = head_valid && m_tready;
	assign occ = q_count + 2'(v_s1);
	assign slot_free = (occ < 2'd2) || pop;

	assign rslt_item = s_tuser || s_tlast;
	assign s_tready = !rslt_item || (!drain_busy_q && slot_free);
	assign in_fire = s_tvalid && s_tready;
	assign issue_rd = drain_busy_q && slot_free;

	cfrw_frame_check #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (in_fire),
		.command  (s_tuser),
		.rx_byte  (s_tdata),
		.end_flag (s_tlast),
		.reload   (reload_q),
		.threshold(thresh_q),
		.chk      (chk)
	);

	// bytes fill one bank while the other drains, so reads and writes never meet
	assign waddr = wr_bank_q ? AW'(chk.wr_idx) + BANK_OFS : AW'(chk.wr_idx);
	assign raddr = drain_bank_q ? AW'(drain_idx_q) + BANK_OFS : AW'(drain_idx_q);

	cfrw_payload_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (chk.wr_en),
		.waddr(waddr),
		.wdata(s_tdata),
		.re   (issue_rd),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_bank_q <= 1'b0;
			drain_bank_q <= 1'b0;
			drain_busy_q <= 1'b0;
			drain_idx_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue_rd || (in_fire && chk.done && !chk.accept);
			if (in_fire && chk.accept) begin
				drain_busy_q <= 1'b1;
				drain_idx_q <= '0;
				drain_bank_q <= wr_bank_q;
				wr_bank_q <= ~wr_bank_q;
			end else if (issue_rd) begin
				drain_idx_q <= drain_idx_q + 1'b1;
				if (drain_idx_q == LAST_IDX) begin
					drain_busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue_rd) begin
			res_s1.kind <= 1'b1;
			res_s1.idx <= drain_idx_q;
			res_s1.pbyte <= '0;
			res_s1.last <= (drain_idx_q == LAST_IDX);
			res_s1.status <= ST_OK;
			res_s1.lost <= 1'b0;
		end else begin
			res_s1.kind <= 1'b0;
			res_s1.idx <= '0;
			res_s1.pbyte <= '0;
			res_s1.last <= 1'b1;
			res_s1.status <= chk.status;
			res_s1.lost <= chk.lost;
		end
	end

	always_comb begin
		push_data = res_s1;
		push_data.pbyte = res_s1.kind ? rdata : '0;
	end

	cfrw_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s1),
		.push_data (push_data),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head),
		.count     (q_count)
	);

	assign m_tvalid = head_valid;
	assign m_tuser = head.kind;
	assign m_tlast = head.last;
	assign m_tdata = {6'b0, head.lost, head.status, head.pbyte, head.idx};

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && rslt_item) |-> !drain_busy_q)
		else $error("result item taken during payload drain");
	assert property (@(posedge clk) disable iff (!arst_n)
		(drain_busy_q && chk.wr_en) |-> (drain_bank_q != wr_bank_q))
		else $error("payload write hit the draining bank");
	assert property (@(posedge clk) disable iff (!arst_n)
		(issue_rd && drain_idx_q == LAST_IDX) |=> !drain_busy_q)
		else $error("drain did not stop after last payload byte");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && chk.accept) |=> (drain_busy_q && drain_idx_q == '0))
		else $error("accepted frame did not start a drain");

endmodule
